>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro places one labeled concurrent assertion on the rising clock edge
// and disables it while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/lcgsc_pkg.sv
// ----------------------------------------------------------------------------
// lcgsc_pkg
// Shared types, constants and generator helpers for the block decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgsc_pkg;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned BYTE_IDX_W  = $clog2(BLOCK_BYTES);
    localparam int unsigned COUNT_W     = 5;

    // Generator constants reduced modulo 256; only the low byte of the
    // multiplier and the increment affects an 8-bit state.
    localparam logic [7:0] LCG_MUL_LOW = 8'd109;
    localparam logic [7:0] LCG_ADD_LOW = 8'd57;

    localparam logic [7:0] PAD_FULL = 8'd16;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic        final_block;
    } cipher_word_t;

    typedef struct packed {
        logic [63:0]        plain_high;
        logic [63:0]        plain_low;
        logic [COUNT_W-1:0] byte_count;
        logic               bad_padding;
        logic               message_end;
    } plain_word_t;

    // A queued job: the accepted word plus its classification.
    typedef struct packed {
        cipher_word_t word;
        logic         first;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IV,
        ST_KEY,
        ST_SWAP,
        ST_PLAIN,
        ST_EMIT
    } back_state_t;

    // Multiplier of the affine map that advances the generator by steps.
    function automatic logic [7:0] lcg_jump_mul(input int unsigned steps);
        logic [7:0] acc;
        acc = 8'd1;
        for (int unsigned k = 0; k < steps; k++) begin
            acc = 8'(acc * LCG_MUL_LOW);
        end
        return acc;
    endfunction

    // Offset of the affine map that advances the generator by steps.
    function automatic logic [7:0] lcg_jump_add(input int unsigned steps);
        logic [7:0] acc;
        acc = 8'd0;
        for (int unsigned k = 0; k < steps; k++) begin
            acc = 8'(acc * LCG_MUL_LOW + LCG_ADD_LOW);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcg_swap_cbc_block_decrypt.sv
// The back end finishes one word before it starts the next; its sixteen swaps
//   run one per cycle, and the first word of a message also draws a new IV.
// The input side keeps accepting while the back end works, up to the queue depth.
// Reset (rst_n, asynchronous, active low) clears the seed to zero, empties the queue,
//   idles the back end and starts the next word as a new message.
// ----------------------------------------------------------------------------
// lcg_swap_cbc_block_decrypt
// Top level of the keystream-swap CBC block decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

// The front end accepts 128-bit ciphertext words and marks the first word of
// each message, so the back end knows when to reload the generator from the
// seed and draw a new IV. A short queue decouples the two, so a word can be
// taken while the back end is still busy or while a finished result waits
// for the consumer.
//
// The back end computes all sixteen keystream bytes of a block at once,
// with precomputed jump constants of the generator, then applies the sixteen
// byte swaps one per cycle, last key byte first. Instead of moving bytes, it
// tracks the destination of every source byte and gathers the result once.
// The chain is XORed in, the ciphertext becomes the new chain, and on the
// final word the pad byte is checked. A pad of sixteen gives no result.
//
// The seed register is sampled only when a message begins.

module lcg_swap_cbc_block_decrypt import lcgsc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       cipher_valid,
    output logic            cipher_ready,
    input  cipher_word_t    cipher_word,
    output logic            plain_valid,
    input  wire logic       plain_ready,
    output plain_word_t     plain_word
);

    logic [7:0] seed_reg;

    logic q_push;
    logic q_ready;
    job_t q_job;
    logic head_valid;
    job_t head_job;
    logic head_pop;

    // The seed register holds the low byte of the password hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    lcgsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cipher_valid (cipher_valid),
        .cipher_word  (cipher_word),
        .cipher_ready (cipher_ready),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    lcgsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .push_ready (q_ready),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    lcgsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .job_valid   (head_valid),
        .job         (head_job),
        .job_pop     (head_pop),
        .plain_valid (plain_valid),
        .plain_ready (plain_ready),
        .plain_word  (plain_word)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lcgsc_front.sv
// ----------------------------------------------------------------------------
// lcgsc_front
// Accepts ciphertext words and tags the first word of each message.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgsc_front import lcgsc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cipher_valid,
    input  cipher_word_t      cipher_word,
    output logic              cipher_ready,
    input  wire logic         q_ready,
    output logic              q_push,
    output job_t              q_job
);

    logic in_msg_reg;
    logic in_msg_next;

    assign cipher_ready = q_ready;
    assign q_push       = cipher_valid && q_ready;

    // A word that arrives outside a message opens one and needs a fresh IV.
    assign q_job.word  = cipher_word;
    assign q_job.first = !in_msg_reg;

    always_comb
    begin
        in_msg_next = in_msg_reg;
        if (q_push)
        begin
            in_msg_next = !cipher_word.final_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcgsc_queue.sv
// ----------------------------------------------------------------------------
// lcgsc_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgsc_queue import lcgsc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    output logic      push_ready,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcgsc_back.sv
// ----------------------------------------------------------------------------
// lcgsc_back
// Generates the keystream, runs the swap network one swap per cycle,
// removes the chain and the padding, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgsc_back import lcgsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] seed,
    input  wire logic       job_valid,
    input  job_t            job,
    output logic            job_pop,
    output logic            plain_valid,
    input  wire logic       plain_ready,
    output plain_word_t     plain_word
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [7:0]            gen_reg;
    logic [7:0]            chain_reg [BLOCK_BYTES];
    logic [7:0]            work_reg  [BLOCK_BYTES];
    logic [7:0]            key_reg   [BLOCK_BYTES];
    logic [BYTE_IDX_W-1:0] dest_reg  [BLOCK_BYTES];
    logic [7:0]            pt_reg    [BLOCK_BYTES];
    logic                  final_reg;
    logic [BYTE_IDX_W-1:0] step_reg;
    logic [BYTE_IDX_W-1:0] step_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    plain_word_t           out_word_reg;

    logic [7:0]            gen_src;
    logic [7:0]            lane      [BLOCK_BYTES];
    logic [7:0]            ct        [BLOCK_BYTES];
    logic [7:0]            scatter   [BLOCK_BYTES];
    logic [127:0]          ct_flat;
    logic [BYTE_IDX_W-1:0] swap_a;
    logic [BYTE_IDX_W-1:0] swap_b;

    logic                  load_iv;
    logic                  load_key;
    logic                  do_swap;
    logic                  do_plain;
    logic                  emit_fire;

    logic [7:0]            pad;
    logic                  pad_full;
    logic                  pad_bad;
    logic                  produce;
    logic [COUNT_W-1:0]    count;
    logic [127:0]          plain_flat;
    plain_word_t           emit_word;

    // Sixteen generator steps at once: lane i holds the state after i+1
    // steps, using the precomputed affine jump for that distance.
    assign gen_src = load_iv ? seed : gen_reg;

    for (genvar i = 0; i < BLOCK_BYTES; i++)
    begin : g_lane
        localparam logic [7:0] JUMP_MUL = lcg_jump_mul(i + 1);
        localparam logic [7:0] JUMP_ADD = lcg_jump_add(i + 1);
        logic [15:0] prod;
        assign prod    = JUMP_MUL * gen_src;
        assign lane[i] = prod[7:0] + JUMP_ADD;
    end

    assign ct_flat = {job.word.cipher_high, job.word.cipher_low};

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            ct[i] = ct_flat[127 - 8 * i -: 8];
        end
    end

    // The key byte in use always sits at the top of the shifting key line.
    assign swap_a = key_reg[BLOCK_BYTES - 1][BYTE_IDX_W-1:0];
    assign swap_b = key_reg[BLOCK_BYTES - 1][7:4];

    // Each source byte tracks where the swaps have moved it; the gather
    // places it back by matching destinations.
    always_comb
    begin
        for (int j = 0; j < BLOCK_BYTES; j++)
        begin
            scatter[j] = 8'd0;
            for (int s = 0; s < BLOCK_BYTES; s++)
            begin
                if (dest_reg[s] == BYTE_IDX_W'(j))
                begin
                    scatter[j] = scatter[j] | work_reg[s];
                end
            end
        end
    end

    // Padding removal on the final block of a message.
    assign pad      = pt_reg[BLOCK_BYTES - 1];
    assign pad_full = (pad == PAD_FULL);
    assign pad_bad  = (pad > PAD_FULL);
    assign produce  = !(final_reg && pad_full);

    always_comb
    begin
        if (!final_reg)
        begin
            count = COUNT_W'(BLOCK_BYTES);
        end
        else if (pad_bad)
        begin
            count = '0;
        end
        else
        begin
            count = COUNT_W'(BLOCK_BYTES) - {1'b0, pad[BYTE_IDX_W-1:0]};
        end
    end

    always_comb
    begin
        for (int j = 0; j < BLOCK_BYTES; j++)
        begin
            plain_flat[127 - 8 * j -: 8] = (COUNT_W'(j) < count) ? pt_reg[j] : 8'd0;
        end
    end

    assign emit_word.plain_high  = plain_flat[127:64];
    assign emit_word.plain_low   = plain_flat[63:0];
    assign emit_word.byte_count  = count;
    assign emit_word.bad_padding = final_reg && pad_bad;
    assign emit_word.message_end = final_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.first ? ST_IV : ST_KEY;
                end
            end
            ST_IV:
            begin
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                state_next = ST_SWAP;
            end
            ST_SWAP:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_PLAIN;
                end
            end
            ST_PLAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || plain_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        load_iv   = 1'b0;
        load_key  = 1'b0;
        do_swap   = 1'b0;
        do_plain  = 1'b0;
        emit_fire = 1'b0;
        case (state_reg)
            ST_IV:
            begin
                load_iv = 1'b1;
            end
            ST_KEY:
            begin
                load_key = 1'b1;
            end
            ST_SWAP:
            begin
                do_swap = 1'b1;
            end
            ST_PLAIN:
            begin
                do_plain = 1'b1;
            end
            ST_EMIT:
            begin
                emit_fire = !out_valid_reg || plain_ready;
            end
            default:
            begin
                load_iv = 1'b0;
            end
        endcase
    end

    assign job_pop = do_plain;

    always_comb
    begin
        step_next = step_reg;
        if (load_key)
        begin
            step_next = BYTE_IDX_W'(BLOCK_BYTES - 1);
        end
        else if (do_swap)
        begin
            step_next = step_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (plain_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_iv || load_key)
        begin
            gen_reg <= lane[BLOCK_BYTES - 1];
        end
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (load_iv)
            begin
                chain_reg[i] <= lane[i];
            end
            else if (do_plain)
            begin
                chain_reg[i] <= ct[i];
            end
            if (load_key)
            begin
                work_reg[i] <= ct[i] ^ lane[i];
                key_reg[i]  <= lane[i];
                dest_reg[i] <= BYTE_IDX_W'(i);
            end
            else if (do_swap)
            begin
                if (dest_reg[i] == swap_a)
                begin
                    dest_reg[i] <= swap_b;
                end
                else if (dest_reg[i] == swap_b)
                begin
                    dest_reg[i] <= swap_a;
                end
                key_reg[i] <= (i == 0) ? 8'd0 : key_reg[(i == 0) ? 0 : i - 1];
            end
            if (do_plain)
            begin
                pt_reg[i] <= scatter[i] ^ chain_reg[i];
            end
        end
        if (do_plain)
        begin
            final_reg <= job.word.final_block;
        end
        if (emit_fire && produce)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign plain_valid = out_valid_reg;
    assign plain_word  = out_word_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lcgsc_checker.sv
// ----------------------------------------------------------------------------
// lcgsc_checker
// Port-level checks on the result channel of the block decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lcgsc_checker import lcgsc_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  plain_valid,
    input wire logic  plain_ready,
    input plain_word_t plain_word
);

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, plain_valid && !plain_ready, plain_valid && $stable(plain_word))

    // Middle words always carry a full block and no padding error.
    `ASSERT_SAME(a_mid_full, clk, rst_n, plain_valid && !plain_word.message_end, plain_word.byte_count == 5'd16 && !plain_word.bad_padding)

    // A bad pad only appears on a final word, with no bytes and zero data.
    `ASSERT_SAME(a_bad_zero, clk, rst_n, plain_valid && plain_word.bad_padding, plain_word.message_end && plain_word.byte_count == 5'd0 && plain_word.plain_high == 64'd0 && plain_word.plain_low == 64'd0)

    // A good final word keeps between one and sixteen bytes.
    `ASSERT_SAME(a_end_count, clk, rst_n, plain_valid && plain_word.message_end && !plain_word.bad_padding, plain_word.byte_count != 5'd0 && plain_word.byte_count <= 5'd16)

endmodule

bind lcg_swap_cbc_block_decrypt lcgsc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .plain_valid (plain_valid),
    .plain_ready (plain_ready),
    .plain_word  (plain_word)
);

`default_nettype wire
